FILE: rtl/wis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wis_pkg;

  // time field width, default
  localparam int unsigned TIME_BITS_DEF = 32;

  // config field widths
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned LEAD_W    = 11;
  localparam int unsigned STREAK_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // clock is trusted only beyond this epoch second
  localparam logic [31:0] CLOCK_EPOCH_MIN = 32'd1600000000;
  // slack before a reading counts as stale
  localparam logic [7:0]  STALE_SLACK     = 8'd30;

  // register reset values
  localparam logic                 PUSH_MODE_RST      = 1'b0;
  localparam logic [PERIOD_W-1:0]  READING_PERIOD_RST = 16'd300;
  localparam logic [LEAD_W-1:0]    POLL_LEAD_RST      = 11'sd15;
  localparam logic [LEAD_W-1:0]    PUSH_LEAD_RST      = -11'sd12;
  localparam logic [PERIOD_W-1:0]  RETRY_INTERVAL_RST = 16'd60;
  localparam logic [STREAK_W-1:0]  RETRY_LIMIT_RST    = 8'd5;
  localparam logic [PERIOD_W-1:0]  MIN_SLEEP_RST      = 16'd20;
  localparam logic [PERIOD_W-1:0]  MAX_SLEEP_RST      = 16'd3600;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUSH_MODE      = 3'd0,
    REG_READING_PERIOD = 3'd1,
    REG_POLL_LEAD      = 3'd2,
    REG_PUSH_LEAD      = 3'd3,
    REG_RETRY_INTERVAL = 3'd4,
    REG_RETRY_LIMIT    = 3'd5,
    REG_MIN_SLEEP      = 3'd6,
    REG_MAX_SLEEP      = 3'd7
  } wis_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE,
    ST_LEAD,
    ST_CHK,
    ST_DIV,
    ST_SILENT,
    ST_ALARM,
    ST_ALARM2,
    ST_CLAMP
  } wis_state_e;

  // handshake from the sequencer to the remainder unit and back
  typedef struct packed {
    logic start;
  } wis_rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wis_rem_stat_t;

endpackage

`default_nettype wire

FILE: rtl/wis_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wis_in_if #(
  parameter int unsigned TIME_BITS = wis_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] time_now;
  logic                 have_reading;
  logic [TIME_BITS-1:0] reading_time;
  logic                 source_answered;
  logic                 fresh_reading;
  logic [TIME_BITS-1:0] alarm_time;

  modport source (
    output valid, time_now, have_reading, reading_time,
           source_answered, fresh_reading, alarm_time,
    input  ready
  );
  modport sink (
    input  valid, time_now, have_reading, reading_time,
           source_answered, fresh_reading, alarm_time,
    output ready
  );
endinterface

interface wis_out_if;
  logic                             valid;
  logic                             ready;
  logic [wis_pkg::PERIOD_W-1:0]     sleep_seconds;
  logic [wis_pkg::STREAK_W-1:0]     retry_count;

  modport source (
    output valid, sleep_seconds, retry_count,
    input  ready
  );
  modport sink (
    input  valid, sleep_seconds, retry_count,
    output ready
  );
endinterface

interface wis_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wis_pkg::CFG_IDX_W-1:0]    index;
  logic [wis_pkg::CFG_DAT_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/wis_rem.sv
`timescale 1ns / 1ps
`default_nettype none

// serial remainder, two dividend bits per cycle, msb first
module wis_rem #(
  parameter int unsigned XW = 33
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wis_pkg::wis_rem_req_t         req_i,
  input  wire logic [XW-1:0]                 dividend_i,
  input  wire logic [wis_pkg::PERIOD_W-1:0]  divisor_i,
  output wis_pkg::wis_rem_stat_t             stat_o,
  output logic [wis_pkg::PERIOD_W-1:0]       rem_o
);

  localparam int unsigned PW = wis_pkg::PERIOD_W;
  localparam int unsigned NS = (XW + 1) / 2;
  localparam int unsigned DW = 2 * NS;
  localparam int unsigned CNT_W = $clog2(NS + 1);

  logic [DW-1:0]    dvd_q, dvd_d;
  logic [PW-1:0]    rem_q, rem_d;
  logic [PW-1:0]    dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [PW:0] r1, r2;
  logic [PW-1:0] r1m;

  always_comb begin
    // two restoring steps
    r1  = {rem_q, dvd_q[DW-1]};
    r1m = (r1 >= {1'b0, dsr_q}) ? PW'(r1 - {1'b0, dsr_q}) : r1[PW-1:0];
    r2  = {r1m, dvd_q[DW-2]};

    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      dvd_d  = DW'(dividend_i);
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(NS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-3:0], 2'b00};
      rem_d = (r2 >= {1'b0, dsr_q}) ? PW'(r2 - {1'b0, dsr_q}) : r2[PW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

FILE: rtl/wake_interval_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// one wake report in, one sleep word out; not ready again until the word is formed
// each report passes AGE, LEAD, SILENT, ALARM, ALARM2 and CLAMP, a grid wake also CHK; when grid
// alignment needs the serial remainder unit it waits in DIV too, and CLAMP waits for a free output
// register; the remainder unit works at 2 bits a cycle, so it sets the pace of such a grid wake
// a new report is accepted while the previous sleep word still waits at the output register
// async active-low reset restores register defaults and clears the retry streak
module wake_interval_scheduler #(
  parameter int unsigned TIME_BITS = wis_pkg::TIME_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wis_cfg_if.sink   cfg_i,
  wis_in_if.sink    in_i,
  wis_out_if.source out_o
);

  localparam int unsigned PW = wis_pkg::PERIOD_W;
  localparam int unsigned LW = wis_pkg::LEAD_W;
  localparam int unsigned SW = wis_pkg::STREAK_W;
  // signed working width for differences plus period and lead
  localparam int unsigned CW = TIME_BITS + 2;
  // differences saturate at +-2^62, reachable only with wide time
  localparam bit SAT_ON = (TIME_BITS > 62);
  localparam logic signed [CW-1:0] CAP = $signed(CW'(64'h4000_0000_0000_0000));
  // remainder dividend width: minv - d stays below 2^XW
  localparam int unsigned XW = (TIME_BITS > 61) ? 63 : TIME_BITS + 1;

  // signed saturated a - b
  function automatic logic signed [CW-1:0] sdiff(
    input logic [TIME_BITS-1:0] a,
    input logic [TIME_BITS-1:0] b
  );
    logic signed [CW-1:0] raw;
    raw = $signed({2'b00, a}) - $signed({2'b00, b});
    if (SAT_ON && raw > CAP) begin
      raw = CAP;
    end else if (SAT_ON && raw < -CAP) begin
      raw = -CAP;
    end
    return raw;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers, written only while idle
  // ---------------------------------------------------------------------------
  logic          push_mode_q;
  logic [PW-1:0] rp_q;
  logic [LW-1:0] poll_lead_q;
  logic [LW-1:0] push_lead_q;
  logic [PW-1:0] retry_int_q;
  logic [SW-1:0] retry_lim_q;
  logic [PW-1:0] min_sleep_q;
  logic [PW-1:0] max_sleep_q;

  wis_pkg::wis_state_e state_q, state_d;

  // config writes take the idle slot ahead of a new report
  assign cfg_i.ready = (state_q == wis_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_mode_q <= wis_pkg::PUSH_MODE_RST;
      rp_q        <= wis_pkg::READING_PERIOD_RST;
      poll_lead_q <= wis_pkg::POLL_LEAD_RST;
      push_lead_q <= wis_pkg::PUSH_LEAD_RST;
      retry_int_q <= wis_pkg::RETRY_INTERVAL_RST;
      retry_lim_q <= wis_pkg::RETRY_LIMIT_RST;
      min_sleep_q <= wis_pkg::MIN_SLEEP_RST;
      max_sleep_q <= wis_pkg::MAX_SLEEP_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (wis_pkg::wis_reg_e'(cfg_i.index))
        wis_pkg::REG_PUSH_MODE:      push_mode_q <= cfg_i.data[0];
        wis_pkg::REG_READING_PERIOD: rp_q        <= cfg_i.data[PW-1:0];
        wis_pkg::REG_POLL_LEAD:      poll_lead_q <= cfg_i.data[LW-1:0];
        wis_pkg::REG_PUSH_LEAD:      push_lead_q <= cfg_i.data[LW-1:0];
        wis_pkg::REG_RETRY_INTERVAL: retry_int_q <= cfg_i.data[PW-1:0];
        wis_pkg::REG_RETRY_LIMIT:    retry_lim_q <= cfg_i.data[SW-1:0];
        wis_pkg::REG_MIN_SLEEP:      min_sleep_q <= cfg_i.data[PW-1:0];
        wis_pkg::REG_MAX_SLEEP:      max_sleep_q <= cfg_i.data[PW-1:0];
      endcase
    end
  end

  // config values widened to the working width
  logic signed [CW-1:0] period_w, minv_w, maxv_w, rint_w, lead_w;
  logic [LW-1:0]        lead_sel;

  assign period_w = $signed(CW'(rp_q));
  assign minv_w   = $signed(CW'(min_sleep_q));
  assign maxv_w   = $signed(CW'(max_sleep_q));
  assign rint_w   = $signed(CW'(retry_int_q));
  assign lead_sel = push_mode_q ? push_lead_q : poll_lead_q;
  assign lead_w   = $signed({{(CW-LW){lead_sel[LW-1]}}, lead_sel});

  // ---------------------------------------------------------------------------
  // sequencer and datapath
  // ---------------------------------------------------------------------------

  // captured report
  logic [TIME_BITS-1:0] now_q, rtime_q, alarm_q;
  logic                 have_q, ans_q, fresh_q;

  logic                 clock_q, clock_d;
  // age of the reading, later reused for the alarm distance
  logic signed [CW-1:0] age_q, age_d;
  // running sleep length
  logic signed [CW-1:0] s_q, s_d;
  logic [SW-1:0]        streak_q, streak_d;

  logic                 out_valid_q, out_valid_d;
  logic [PW-1:0]        out_sleep_q, out_sleep_d;
  logic [SW-1:0]        out_cnt_q, out_cnt_d;

  // remainder unit
  wis_pkg::wis_rem_req_t  rem_req;
  wis_pkg::wis_rem_stat_t rem_stat;
  logic [PW-1:0]          rem;
  logic signed [CW-1:0]   x_w;

  // scratch
  logic signed [CW-1:0] lo_cl, da_w;
  logic                 stale;

  assign x_w = minv_w - s_q;

  wis_rem #(
    .XW (XW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (rem_req),
    .dividend_i (x_w[XW-1:0]),
    .divisor_i  (rp_q),
    .stat_o     (rem_stat),
    .rem_o      (rem)
  );

  assign in_i.ready          = (state_q == wis_pkg::ST_IDLE) && !cfg_i.valid;
  assign out_o.valid         = out_valid_q;
  assign out_o.sleep_seconds = out_sleep_q;
  assign out_o.retry_count   = out_cnt_q;

  always_comb begin
    state_d       = state_q;
    clock_d       = clock_q;
    age_d         = age_q;
    s_d           = s_q;
    streak_d      = streak_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_sleep_d   = out_sleep_q;
    out_cnt_d     = out_cnt_q;
    rem_req.start = 1'b0;
    stale         = ans_q && !fresh_q
                    && (age_q > period_w + $signed(CW'(wis_pkg::STALE_SLACK)))
                    && (streak_q < retry_lim_q);
    lo_cl         = (s_q < minv_w) ? minv_w : s_q;
    da_w          = (age_q < minv_w) ? minv_w : age_q;

    unique case (state_q)
      wis_pkg::ST_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          state_d = wis_pkg::ST_AGE;
        end
      end

      // trusted clock check and reading age
      wis_pkg::ST_AGE: begin
        clock_d = (now_q > TIME_BITS'(wis_pkg::CLOCK_EPOCH_MIN)) && have_q
                  && (rtime_q != '0);
        age_d   = sdiff(now_q, rtime_q);
        state_d = wis_pkg::ST_LEAD;
      end

      // untrusted clock takes the period, else stale retry, or raw grid wake relative to the last reading
      wis_pkg::ST_LEAD: begin
        if (!clock_q) begin
          s_d     = period_w;
          state_d = wis_pkg::ST_SILENT;
        end else if (stale) begin
          streak_d = streak_q + SW'(1);
          s_d      = rint_w;
          state_d  = wis_pkg::ST_SILENT;
        end else begin
          s_d     = period_w + lead_w - age_q;
          state_d = wis_pkg::ST_CHK;
        end
      end

      // wake already behind min sleep: push it forward on the grid, or to min sleep when the period is zero
      wis_pkg::ST_CHK: begin
        if (s_q < minv_w) begin
          if (rp_q != '0) begin
            rem_req.start = 1'b1;
            state_d       = wis_pkg::ST_DIV;
          end else begin
            s_d     = minv_w;
            state_d = wis_pkg::ST_SILENT;
          end
        end else begin
          state_d = wis_pkg::ST_SILENT;
        end
      end

      // minv + ((period - (minv - d) mod period) mod period)
      wis_pkg::ST_DIV: begin
        if (rem_stat.done) begin
          s_d     = (rem == '0) ? minv_w : minv_w + period_w - $signed(CW'(rem));
          state_d = wis_pkg::ST_SILENT;
        end
      end

      // silent source retry up to the limit, else untrusted clock takes the period; fresh ends the streak
      wis_pkg::ST_SILENT: begin
        if (!ans_q) begin
          if (streak_q < retry_lim_q) begin
            streak_d = streak_q + SW'(1);
            if (s_q > rint_w) begin
              s_d = rint_w;
            end
          end else if (!clock_q) begin
            s_d = period_w;
          end
        end
        if (fresh_q) begin
          streak_d = '0;
        end
        state_d = wis_pkg::ST_ALARM;
      end

      wis_pkg::ST_ALARM: begin
        age_d   = sdiff(alarm_q, now_q);
        state_d = wis_pkg::ST_ALARM2;
      end

      // pending alarm can only shorten the sleep
      wis_pkg::ST_ALARM2: begin
        if ((alarm_q != '0) && (da_w < s_q)) begin
          s_d = da_w;
        end
        state_d = wis_pkg::ST_CLAMP;
      end

      // min clamp then max clamp, max wins; wait for a free output register
      wis_pkg::ST_CLAMP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sleep_d = (lo_cl > maxv_w) ? max_sleep_q : lo_cl[PW-1:0];
          out_cnt_d   = streak_q;
          state_d     = wis_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wis_pkg::ST_IDLE;
      streak_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      streak_q    <= streak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      now_q   <= in_i.time_now;
      rtime_q <= in_i.reading_time;
      alarm_q <= in_i.alarm_time;
      have_q  <= in_i.have_reading;
      ans_q   <= in_i.source_answered;
      fresh_q <= in_i.fresh_reading;
    end
    clock_q     <= clock_d;
    age_q       <= age_d;
    s_q         <= s_d;
    out_sleep_q <= out_sleep_d;
    out_cnt_q   <= out_cnt_d;
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  // clock period and run bounds
  localparam int          CLK_HALF        = 6;
  localparam int          RESET_CYCLES    = 6;
  localparam int          DRAIN_CYCLES    = 40;   // settle time once every owed word is back
  localparam int          HOLD_OFF_CYCLES = 120;  // long receiver stall, block must back up
  localparam int          PHASES          = 7;
  localparam int          PHASE_ITEMS     = 56;
  localparam longint      TIMEOUT_NS      = 5_000_000;

  // behavior constants
  localparam longint unsigned TRUST_EPOCH  = 64'd1600000000;
  localparam longint          STALE_MARGIN = 30;
  localparam longint          GAP_CAP      = longint'(1) << 62;
  localparam logic [31:0]     T0           = 32'd1700000000;

  // one wake report as offered on the input channel
  typedef struct {
    logic [31:0] now;
    logic        have;
    logic [31:0] rtime;
    logic        answered;
    logic        fresh;
    logic [31:0] alarm;
  } wake_report_t;

  // one sleep word as seen on the output channel
  typedef struct packed {
    logic [15:0] sleep;
    logic [7:0]  retries;
  } sleep_word_t;

  // directed stimulus row, the word is typed in only where obvious
  typedef struct {
    wake_report_t r;
    bit           typed;
    sleep_word_t  word;
  } wake_row_t;

  // one register setting for a phase
  typedef struct {
    bit mode;
    int period;
    int poll;
    int push;
    int retry_iv;
    int lim;
    int min_s;
    int max_s;
  } sched_setting_t;

  logic clk;
  logic rst_n;

  wis_cfg_if                     cfg_if ();
  wis_in_if #(.TIME_BITS(32))    in_if ();
  wis_out_if                     out_if ();

  wake_interval_scheduler #(
    .TIME_BITS(32)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the register file and the retry streak
  logic               cfg_push_mode;
  logic [15:0]        cfg_period;
  logic signed [10:0] cfg_poll_lead;
  logic signed [10:0] cfg_push_lead;
  logic [15:0]        cfg_retry_iv;
  logic [7:0]         cfg_retry_limit;
  logic [15:0]        cfg_min_sleep;
  logic [15:0]        cfg_max_sleep;
  logic [7:0]         streak_model;

  // sleep words still owed by the block, oldest first
  sleep_word_t pending_words[$];

  int mismatches;
  bit quiet;          // no idling on either side
  bit hold_off_req;   // asks the receiver for one long stall

  wake_row_t wake_table[24];

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // a - b in seconds, signed, saturating at 2^62
  function automatic longint time_gap(longint unsigned a, longint unsigned b);
    longint unsigned u;
    if (a >= b) begin
      u = a - b;
      return (u > GAP_CAP) ? GAP_CAP : longint'(u);
    end
    u = b - a;
    return (u > GAP_CAP) ? -GAP_CAP : -longint'(u);
  endfunction

  // expected sleep word for one report, advances the shadow streak
  function automatic sleep_word_t plan_sleep(wake_report_t r);
    longint      period;
    longint      minv;
    longint      s;
    longint      age;
    longint      lead;
    longint      d;
    longint      k;
    bit          trusted;
    sleep_word_t w;
    period  = longint'(cfg_period);
    minv    = longint'(cfg_min_sleep);
    s       = period;
    trusted = (longint'(r.now) > TRUST_EPOCH) && r.have && (r.rtime != 32'd0);

    if (trusted) begin
      age = time_gap(r.now, r.rtime);
      // answered but nothing new and the reading is overdue: short retry
      if (r.answered && !r.fresh && age > period + STALE_MARGIN &&
          streak_model < cfg_retry_limit) begin
        streak_model++;
        s = longint'(cfg_retry_iv);
      end else begin
        // next grid point after the last reading, shifted by the mode lead
        lead = cfg_push_mode ? longint'(cfg_push_lead) : longint'(cfg_poll_lead);
        d = time_gap(r.rtime, r.now) + period + lead;
        if (d < minv) begin
          if (period > 0) begin
            k = (minv - d + period - 1) / period;
            d += k * period;
          end else begin
            d = minv;
          end
        end
        s = d;
      end
    end

    // silent source retries until the limit, then an untrusted clock falls back to the period
    if (!r.answered) begin
      if (streak_model < cfg_retry_limit) begin
        streak_model++;
        if (s > longint'(cfg_retry_iv)) s = longint'(cfg_retry_iv);
      end else if (!trusted) begin
        s = period;
      end
    end
    if (r.fresh) streak_model = 8'd0;

    // an alarm can only shorten the sleep
    if (r.alarm != 32'd0) begin
      d = time_gap(r.alarm, r.now);
      if (d < minv) d = minv;
      if (d < s) s = d;
    end
    if (s < minv) s = minv;
    if (s > longint'(cfg_max_sleep)) s = longint'(cfg_max_sleep);

    w.sleep   = s[15:0];
    w.retries = streak_model;
    return w;
  endfunction

  function automatic wake_row_t wake_row(logic [31:0] now, bit have, logic [31:0] rtime,
                                         bit answered, bit fresh, logic [31:0] alarm,
                                         bit typed, int sleep, int retries);
    wake_row_t row;
    row.r.now      = now;
    row.r.have     = have;
    row.r.rtime    = rtime;
    row.r.answered = answered;
    row.r.fresh    = fresh;
    row.r.alarm    = alarm;
    row.typed      = typed;
    row.word       = {16'(sleep), 8'(retries)};
    return row;
  endfunction

  // random report, mostly a trusted clock with the reading a few periods away
  function automatic wake_report_t make_report();
    wake_report_t r;
    int unsigned  span;
    int unsigned  pick;
    span = 4 * int'(cfg_period) + 100;
    r.now = ($urandom_range(0, 9) < 8) ? $urandom_range(1600000001, 32'hFFFF_FFFF)
                                       : $urandom;
    r.have = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 14)      r.rtime = r.now - $urandom_range(0, span);
    else if (pick < 17) r.rtime = r.now + $urandom_range(0, span);
    else if (pick < 18) r.rtime = 32'd0;
    else                r.rtime = $urandom;
    r.answered = ($urandom_range(0, 3) != 0);
    r.fresh    = ($urandom_range(0, 4) < 2);
    pick = $urandom_range(0, 19);
    if (pick < 10)      r.alarm = 32'd0;
    else if (pick < 17) r.alarm = r.now + $urandom_range(0, 5000) - 32'd1000;
    else                r.alarm = $urandom;
    return r;
  endfunction

  // offer one report, wait for the handshake, then book its sleep word
  task automatic offer_report(input wake_report_t r, input bit typed,
                              input sleep_word_t typed_word);
    sleep_word_t w;
    in_if.valid           <= 1'b1;
    in_if.time_now        <= r.now;
    in_if.have_reading    <= r.have;
    in_if.reading_time    <= r.rtime;
    in_if.source_answered <= r.answered;
    in_if.fresh_reading   <= r.fresh;
    in_if.alarm_time      <= r.alarm;
    do @(posedge clk); while (!in_if.ready);
    w = plan_sleep(r);
    pending_words.push_back(typed ? typed_word : w);
    // random source gap; with no gap valid just stays high for the next word
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input wis_pkg::wis_reg_e idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      wis_pkg::REG_PUSH_MODE:      cfg_push_mode   = val[0];
      wis_pkg::REG_READING_PERIOD: cfg_period      = val;
      wis_pkg::REG_POLL_LEAD:      cfg_poll_lead   = val[10:0];
      wis_pkg::REG_PUSH_LEAD:      cfg_push_lead   = val[10:0];
      wis_pkg::REG_RETRY_INTERVAL: cfg_retry_iv    = val;
      wis_pkg::REG_RETRY_LIMIT:    cfg_retry_limit = val[7:0];
      wis_pkg::REG_MIN_SLEEP:      cfg_min_sleep   = val;
      wis_pkg::REG_MAX_SLEEP:      cfg_max_sleep   = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait until every owed word is back, then let the block settle
  task automatic drain_words();
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: short random stalls, one long hold-off on request
  initial begin : word_sink
    int n;
    out_if.ready <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // every accepted word against the oldest one owed
  always @(posedge clk) begin : word_check
    sleep_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: sleep=%0d retries=%0d",
                   out_if.sleep_seconds, out_if.retry_count);
      end else begin
        want = pending_words.pop_front();
        if (out_if.sleep_seconds !== want.sleep || out_if.retry_count !== want.retries) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected sleep=%0d retries=%0d, got sleep=%0d retries=%0d",
                     want.sleep, want.retries, out_if.sleep_seconds, out_if.retry_count);
        end
      end
    end
  end

  initial begin : stimulus
    sched_setting_t set;
    wake_report_t   r;
    sleep_word_t    none;
    mismatches   = 0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    none         = '0;

    // every input known from time zero
    rst_n                 <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= wis_pkg::REG_PUSH_MODE;
    cfg_if.data           <= '0;
    in_if.valid           <= 1'b0;
    in_if.time_now        <= '0;
    in_if.have_reading    <= 1'b0;
    in_if.reading_time    <= '0;
    in_if.source_answered <= 1'b0;
    in_if.fresh_reading   <= 1'b0;
    in_if.alarm_time      <= '0;

    // register defaults after reset
    cfg_push_mode   = 1'b0;
    cfg_period      = 16'd300;
    cfg_poll_lead   = 11'sd15;
    cfg_push_lead   = -11'sd12;
    cfg_retry_iv    = 16'd60;
    cfg_retry_limit = 8'd5;
    cfg_min_sleep   = 16'd20;
    cfg_max_sleep   = 16'd3600;
    streak_model    = 8'd0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset defaults
    wake_table[0]  = wake_row(32'd0, 0, 32'd0, 1, 0, 32'd0, 1, 300, 0);       // untrusted clock
    wake_table[1]  = wake_row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF,
                              1, 20, 0);                                      // all ones, alarm now
    // silent source: five short retries, then the limit is reached
    wake_table[2]  = wake_row(32'd0, 0, 32'd0, 0, 0, 32'd0, 1, 60, 1);
    wake_table[3]  = wake_row(32'd0, 0, 32'd0, 0, 0, 32'd0, 1, 60, 2);
    wake_table[4]  = wake_row(32'd0, 0, 32'd0, 0, 0, 32'd0, 1, 60, 3);
    wake_table[5]  = wake_row(32'd0, 0, 32'd0, 0, 0, 32'd0, 1, 60, 4);
    wake_table[6]  = wake_row(32'd0, 0, 32'd0, 0, 0, 32'd0, 1, 60, 5);
    wake_table[7]  = wake_row(32'd0, 0, 32'd0, 0, 0, 32'd0, 1, 300, 5);
    wake_table[8]  = wake_row(T0, 1, T0 - 1000, 1, 0, 32'd0, 0, 0, 0);       // stale, limit hit
    wake_table[9]  = wake_row(32'd0, 0, 32'd0, 1, 1, 32'd0, 1, 300, 0);      // fresh clears streak
    wake_table[10] = wake_row(T0, 1, T0 - 1000, 1, 0, 32'd0, 1, 60, 1);      // stale answer retry
    wake_table[11] = wake_row(T0, 1, T0 - 100, 1, 1, 32'd0, 1, 215, 0);      // plain grid wake
    wake_table[12] = wake_row(T0, 1, T0 - 100, 0, 0, 32'd0, 1, 60, 1);       // silent, trusted
    wake_table[13] = wake_row(T0, 1, T0 - 100, 0, 1, 32'd0, 1, 60, 0);       // silent but fresh
    wake_table[14] = wake_row(T0, 1, T0 - 1000, 1, 1, 32'd0, 0, 0, 0);       // grid steps forward
    wake_table[15] = wake_row(T0, 1, T0 - 100, 1, 1, T0 - 50, 1, 20, 0);     // alarm in the past
    wake_table[16] = wake_row(T0, 1, T0 - 100, 1, 1, T0 + 100, 1, 100, 0);   // alarm shortens
    wake_table[17] = wake_row(T0, 1, T0 + 5000, 1, 1, 32'd0, 1, 3600, 0);    // max clamp
    wake_table[18] = wake_row(32'd1600000000, 1, 32'd1599999990, 1, 0, 32'd0,
                              1, 300, 0);                                    // epoch edge, untrusted
    wake_table[19] = wake_row(32'd1600000001, 1, 32'd1599999991, 1, 1, 32'd0,
                              1, 305, 0);                                    // just past epoch
    wake_table[20] = wake_row(T0, 0, T0 - 100, 1, 1, 32'd0, 1, 300, 0);      // no stored reading
    wake_table[21] = wake_row(T0, 1, 32'd0, 1, 1, 32'd0, 1, 300, 0);         // reading time unknown
    wake_table[22] = wake_row(T0, 1, T0 - 330, 1, 0, 32'd0, 0, 0, 0);        // age on the slack
    wake_table[23] = wake_row(T0, 1, T0 - 331, 1, 0, 32'd0, 1, 60, 1);       // one past the slack

    foreach (wake_table[i])
      offer_report(wake_table[i].r, wake_table[i].typed, wake_table[i].word);

    // random part, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      drain_words();
      case (p)
        0: set = '{1'b1, 300, 15, -12, 60, 5, 20, 3600};          // push mode
        1: set = '{1'b0, 1, -1024, 1023, 1, 0, 1, 65535};         // low extremes
        2: set = '{1'b1, 65535, 1023, -1024, 65535, 255, 65535, 65535};
        3: set = '{1'b0, 0, 15, -12, 60, 3, 20, 3600};            // zero period
        4: set = '{1'b1, 120, 100, -100, 30, 2, 500, 100};        // min above max
        default: begin
          set.mode     = $urandom_range(0, 1);
          set.period   = $urandom_range(1, 2000);
          set.poll     = int'($urandom_range(0, 2047)) - 1024;
          set.push     = int'($urandom_range(0, 2047)) - 1024;
          set.retry_iv = $urandom_range(1, 2000);
          set.lim      = $urandom_range(0, 8);
          set.min_s    = $urandom_range(1, 500);
          set.max_s    = $urandom_range(1, 5000);
        end
      endcase
      // the last phase runs with no idling at all
      if (p == PHASES - 1) quiet = 1'b1;

      write_reg(wis_pkg::REG_PUSH_MODE,      16'(set.mode));
      write_reg(wis_pkg::REG_READING_PERIOD, 16'(set.period));
      write_reg(wis_pkg::REG_POLL_LEAD,      16'(set.poll));
      write_reg(wis_pkg::REG_PUSH_LEAD,      16'(set.push));
      write_reg(wis_pkg::REG_RETRY_INTERVAL, 16'(set.retry_iv));
      write_reg(wis_pkg::REG_RETRY_LIMIT,    16'(set.lim));
      write_reg(wis_pkg::REG_MIN_SLEEP,      16'(set.min_s));
      write_reg(wis_pkg::REG_MAX_SLEEP,      16'(set.max_s));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // receiver backs off for a long stretch while reports keep coming
        if (p == 1 && n == 5) hold_off_req = 1'b1;
        // source goes quiet until every word is back
        if (p == 2 && n == 25) drain_words();
        r = make_report();
        offer_report(r, 1'b0, none);
      end
    end

    drain_words();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
